### sv/mcvc_pkg.sv
// Shared types and constants for the most common value counter.
package mcvc_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int KEY_W      = 64;
  localparam int OUT_CNT_W  = 32;
  localparam int DISTINCT_W = 7;

  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_TUSER_W = 1;

  typedef struct packed {
    logic clr;
    logic eval;
    logic chk;
  } mcvc_ctl_t;

endpackage

### sv/mcvc_ram.sv
// Generic simple dual-port RAM with registered read data.
module mcvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/mcvc_unit.sv
// Shared compare unit: entry match, saturating count update and running mode selection.
module mcvc_unit #(
  parameter int COUNT_WIDTH = mcvc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  mcvc_pkg::mcvc_ctl_t        ctl,
  input  logic [mcvc_pkg::KEY_W-1:0] ent_key,
  input  logic                       ent_tag,
  input  logic [COUNT_WIDTH-1:0]     ent_total,
  input  logic [mcvc_pkg::KEY_W-1:0] item_key,
  input  logic                       item_tag,
  output logic                       match,
  output logic [COUNT_WIDTH-1:0]     tot_upd,
  output logic [mcvc_pkg::KEY_W-1:0] best_key_r,
  output logic                       best_tag_r,
  output logic [COUNT_WIDTH-1:0]     best_total_r
);

  logic is_false;
  logic take;

  always_comb begin
    match    = ctl.chk && (ent_tag == item_tag) && (ent_key == item_key);
    tot_upd  = ent_total;
    if (match && (ent_total != {COUNT_WIDTH{1'b1}})) begin
      tot_upd = ent_total + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    end
    is_false = ent_tag && (ent_key == '0);
    take     = (tot_upd > best_total_r) || ((tot_upd == best_total_r) && is_false);
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      best_key_r   <= '0;
      best_tag_r   <= 1'b0;
      best_total_r <= '0;
    end else if (ctl.eval && take) begin
      best_key_r   <= ent_key;
      best_tag_r   <= ent_tag;
      best_total_r <= tot_upd;
    end
  end

endmodule

### sv/most_common_value_counter.sv
// Top level of the most common value counter: sequencer, entry table and stream ports.
//
//   channel | direction | tdata                                   | tuser
//   in_     | slave     | start_new, value, zero pad              | value_is_bool
//   out_    | master    | mode_value, mode_count, distinct, drop  | mode_is_bool
//
// An item walks the table RAM from its first entry up to the entry count, and one entry is read per
// cycle; the registered read of the last entry drains before the walk ends. A matching entry is
// written back with its new count; if none matched, a new entry is appended after the walk, or
// the item is flagged as dropped when the table is full.
// Reset clears the sequencer and the entry count only; the table is not swept.
// in_tready is high only while idle; the result holds until out_tready takes it.
module most_common_value_counter #(
  parameter int TABLE_DEPTH = mcvc_pkg::TABLE_DEPTH_DEF,
  parameter int COUNT_WIDTH = mcvc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // start_new [0], value [64:1], zero [71:65]
  input  logic [mcvc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // value_is_bool [0]
  input  logic [mcvc_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // mode_value [63:0], mode_count [95:64], distinct_entries [102:96], dropped [103]
  output logic [mcvc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // mode_is_bool [0]
  output logic [mcvc_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W = mcvc_pkg::KEY_W + 1 + COUNT_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_APPEND, S_OUT} state_t;

  state_t                       state_r, state_nxt;
  logic [mcvc_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic                         tag_r, tag_nxt;
  logic [CNT_W-1:0]             used_r, used_nxt;
  logic [CNT_W-1:0]             rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]             pend_idx_r, pend_idx_nxt;
  logic                         pend_r, pend_nxt;
  logic                         hit_r, hit_nxt;
  logic                         drop_r, drop_nxt;

  logic                         in_fire;
  logic                         issue;
  logic [mcvc_pkg::KEY_W-1:0]   in_value;
  logic                         in_tag;
  logic [mcvc_pkg::KEY_W-1:0]   in_key_norm;

  logic                         we;
  logic [IDX_W-1:0]             waddr;
  logic [ENT_W-1:0]             wdata;
  logic [ENT_W-1:0]             rdata;

  mcvc_pkg::mcvc_ctl_t          ctl;
  logic [mcvc_pkg::KEY_W-1:0]   u_key;
  logic                         u_tag;
  logic [COUNT_WIDTH-1:0]       u_total;
  logic                         match;
  logic [COUNT_WIDTH-1:0]       tot_upd;
  logic [mcvc_pkg::KEY_W-1:0]   best_key_r;
  logic                         best_tag_r;
  logic [COUNT_WIDTH-1:0]       best_total_r;

  assign in_tready   = (state_r == S_IDLE);
  assign in_fire     = in_tvalid && in_tready;
  assign in_value    = in_tdata[mcvc_pkg::KEY_W:1];
  assign in_tag      = in_tuser[0];
  assign in_key_norm = in_tag ? {{(mcvc_pkg::KEY_W-1){1'b0}}, |in_value} : in_value;
  assign issue       = (rd_idx_r < used_r);

  always_comb begin
    state_nxt    = state_r;
    key_nxt      = key_r;
    tag_nxt      = tag_r;
    used_nxt     = used_r;
    rd_idx_nxt   = rd_idx_r;
    pend_idx_nxt = pend_idx_r;
    pend_nxt     = 1'b0;
    hit_nxt      = hit_r;
    drop_nxt     = drop_r;
    we           = 1'b0;
    waddr        = pend_idx_r;
    wdata        = {tot_upd, rdata[mcvc_pkg::KEY_W:0]};
    ctl          = '0;
    u_key        = rdata[mcvc_pkg::KEY_W-1:0];
    u_tag        = rdata[mcvc_pkg::KEY_W];
    u_total      = rdata[ENT_W-1:mcvc_pkg::KEY_W+1];
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt    = in_key_norm;
          tag_nxt    = in_tag;
          rd_idx_nxt = '0;
          hit_nxt    = 1'b0;
          drop_nxt   = 1'b0;
          ctl.clr    = 1'b1;
          if (in_tdata[0]) begin
            used_nxt = '0;
          end
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        if (issue) begin
          rd_idx_nxt   = rd_idx_r + {{(CNT_W-1){1'b0}}, 1'b1};
          pend_idx_nxt = rd_idx_r[IDX_W-1:0];
          pend_nxt     = 1'b1;
        end
        if (pend_r) begin
          ctl.chk  = 1'b1;
          ctl.eval = 1'b1;
          if (match) begin
            we      = 1'b1;
            hit_nxt = 1'b1;
          end
        end
        if (!issue && !pend_r) begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        u_key   = key_r;
        u_tag   = tag_r;
        u_total = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
        waddr   = used_r[IDX_W-1:0];
        wdata   = {u_total, tag_r, key_r};
        if (!hit_r) begin
          if (used_r < CNT_W'(TABLE_DEPTH)) begin
            we       = 1'b1;
            ctl.eval = 1'b1;
            used_nxt = used_r + {{(CNT_W-1){1'b0}}, 1'b1};
          end else begin
            drop_nxt = 1'b1;
          end
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      pend_r  <= 1'b0;
      hit_r   <= 1'b0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      pend_r  <= pend_nxt;
      hit_r   <= hit_nxt;
      drop_r  <= drop_nxt;
    end
    key_r      <= key_nxt;
    tag_r      <= tag_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
  end

  mcvc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  mcvc_unit #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_unit (
    .clk          (clk),
    .ctl          (ctl),
    .ent_key      (u_key),
    .ent_tag      (u_tag),
    .ent_total    (u_total),
    .item_key     (key_r),
    .item_tag     (tag_r),
    .match        (match),
    .tot_upd      (tot_upd),
    .best_key_r   (best_key_r),
    .best_tag_r   (best_tag_r),
    .best_total_r (best_total_r)
  );

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {drop_r,
                       mcvc_pkg::DISTINCT_W'(used_r),
                       mcvc_pkg::OUT_CNT_W'(best_total_r),
                       best_key_r};
  assign out_tuser  = best_tag_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    !(hit_r && match))
    else $error("second matching entry in one walk");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && drop_r) |-> (used_r == CNT_W'(TABLE_DEPTH)) && !hit_r)
    else $error("drop flagged while table not full");

  a_mode_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (best_total_r != '0) && (used_r != '0))
    else $error("result with empty mode");

endmodule

### dv/most_common_value_counter_checker.sv
// Checker for the most common value counter: predicts each result from the input transfers and compares.
module most_common_value_counter_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  // start_new [0], value [64:1], zero [71:65]
  input  logic [mcvc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // value_is_bool [0]
  input  logic [mcvc_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  // mode_value [63:0], mode_count [95:64], distinct_entries [102:96], dropped [103]
  input  logic [mcvc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // mode_is_bool [0]
  input  logic [mcvc_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output int                                fail_count,
  output int                                pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = mcvc_pkg::TABLE_DEPTH_DEF;
  localparam logic [mcvc_pkg::COUNT_WIDTH_DEF-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [mcvc_pkg::KEY_W-1:0]      value;
    logic                            is_bool;
    logic [mcvc_pkg::OUT_CNT_W-1:0]  count;
    logic [mcvc_pkg::DISTINCT_W-1:0] distinct;
    logic                            dropped;
  } mode_report_t;

  logic [mcvc_pkg::KEY_W-1:0]           tbl_key  [DEPTH];
  logic                                 tbl_bool [DEPTH];
  logic [mcvc_pkg::COUNT_WIDTH_DEF-1:0] tbl_cnt  [DEPTH];
  int unsigned                          n_used;

  mode_report_t mode_reports_q[$];
  mode_report_t want;
  mode_report_t got;
  int           errs;

  function automatic mode_report_t count_and_find_mode(input logic restart,
                                                       input logic [63:0] raw,
                                                       input logic as_bool);
    logic [63:0]  key;
    logic         hit;
    logic         is_false;
    mode_report_t r;
    key = as_bool ? {63'd0, raw != 64'd0} : raw;
    hit = 1'b0;
    r = '0;
    if (restart) n_used = 0;
    for (int i = 0; i < n_used && !hit; i++) begin
      if (tbl_bool[i] == as_bool && tbl_key[i] == key) begin
        if (tbl_cnt[i] != CNT_MAX) tbl_cnt[i] = tbl_cnt[i] + 1'b1;
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (n_used < DEPTH) begin
        tbl_key[n_used] = key;
        tbl_bool[n_used] = as_bool;
        tbl_cnt[n_used] = 1;
        n_used++;
      end else begin
        r.dropped = 1'b1;
      end
    end
    // Insertion order decides ties, except that a boolean false entry takes over a tie.
    for (int i = 0; i < n_used; i++) begin
      is_false = tbl_bool[i] && tbl_key[i] == 64'd0;
      if (tbl_cnt[i] > r.count || (tbl_cnt[i] == r.count && is_false)) begin
        r.value = tbl_key[i];
        r.is_bool = tbl_bool[i];
        r.count = tbl_cnt[i];
      end
    end
    r.distinct = n_used[mcvc_pkg::DISTINCT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      n_used = 0;
      mode_reports_q.delete();
      pending_count <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        mode_reports_q.push_back(count_and_find_mode(in_tdata[0], in_tdata[64:1], in_tuser[0]));
      end
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[63:0];
        got.count = out_tdata[95:64];
        got.distinct = out_tdata[102:96];
        got.dropped = out_tdata[103];
        got.is_bool = out_tuser[0];
        if (mode_reports_q.size() == 0) begin
          $error("Result transfer with no item waiting: mode_value %0h", got.value);
          errs++;
        end else begin
          want = mode_reports_q.pop_front();
          check_field("mode_value", want.value, got.value);
          check_field("mode_is_bool", 64'(want.is_bool), 64'(got.is_bool));
          check_field("mode_count", 64'(want.count), 64'(got.count));
          check_field("distinct_entries", 64'(want.distinct), 64'(got.distinct));
          check_field("dropped", 64'(want.dropped), 64'(got.dropped));
        end
      end
      pending_count <= mode_reports_q.size();
    end
    fail_count <= errs;
  end

endmodule

### dv/most_common_value_counter_tb.sv
// Testbench top for the most common value counter: clock, reset, stimulus and verdict.
module most_common_value_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {RUN_SMALL, RUN_BOOL, RUN_FILL, RUN_WIDE, RUN_NOISE} run_kind_t;

  localparam int N_ITEMS   = 1700;
  localparam int CALM_FROM = 1500;
  localparam int POOL_MAX  = 80;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [mcvc_pkg::IN_TDATA_W-1:0]   in_tdata = '0;
  logic [mcvc_pkg::IN_TUSER_W-1:0]   in_tuser = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [mcvc_pkg::OUT_TDATA_W-1:0]  out_tdata;
  logic [mcvc_pkg::OUT_TUSER_W-1:0]  out_tuser;
  int                                fail_count;
  int                                pending_count;

  int          idle_pct = 30;
  bit          calm = 1'b0;
  int          sent = 0;
  int          ready_hold = 0;
  run_kind_t   run_kind;
  int          run_len;
  int          pool_n;
  int          bool_pct;
  int          pick;
  logic [63:0] base;
  logic [63:0] pool_key  [POOL_MAX];
  logic        pool_bool [POOL_MAX];

  most_common_value_counter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  most_common_value_counter_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("[most_common_value_counter] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      out_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
      out_tready <= 1'b0;
      ready_hold <= $urandom_range(0, 6);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic count_value(input logic start_new, input logic [63:0] value,
                             input logic value_is_bool);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, value, start_new};
    in_tuser <= value_is_bool;
    @(posedge clk iff in_tready);
    sent++;
    calm = sent >= CALM_FROM;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Plain zero against boolean false, then boolean true from several nonzero keys.
    count_value(1'b1, 64'd0, 1'b0);
    count_value(1'b0, 64'd0, 1'b1);
    count_value(1'b0, 64'd5, 1'b1);
    count_value(1'b0, '1, 1'b1);
    count_value(1'b0, 64'd1, 1'b0);
    count_value(1'b0, '1, 1'b0);
    count_value(1'b0, '1, 1'b0);
    count_value(1'b0, 64'h8000_0000_0000_0000, 1'b1);
    // A later boolean false takes over a tie; an earlier one is kept.
    count_value(1'b1, 64'h8000_0000_0000_0001, 1'b0);
    count_value(1'b0, 64'd0, 1'b1);
    count_value(1'b0, 64'd0, 1'b1);
    count_value(1'b1, 64'd0, 1'b1);
    count_value(1'b0, 64'd7, 1'b0);
    count_value(1'b0, 64'd1, 1'b1);
    count_value(1'b1, 64'd3, 1'b0);
    count_value(1'b1, 64'd3, 1'b0);
    count_value(1'b0, 64'h5555_5555_5555_5555, 1'b0);
    count_value(1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);

    while (sent < N_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: run_kind = RUN_SMALL;
        3, 4:    run_kind = RUN_BOOL;
        5, 6:    run_kind = RUN_FILL;
        7:       run_kind = RUN_WIDE;
        default: run_kind = RUN_NOISE;
      endcase
      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      pool_n = 0;
      bool_pct = 50;
      case (run_kind)
        RUN_SMALL: begin
          pool_n = $urandom_range(1, 6);
          run_len = $urandom_range(1, 40);
          bool_pct = 25;
        end
        RUN_BOOL: begin
          pool_n = $urandom_range(2, 5);
          run_len = $urandom_range(1, 30);
          bool_pct = 80;
        end
        RUN_FILL: begin
          pool_n = $urandom_range(64, 72);
          run_len = $urandom_range(70, 140);
          bool_pct = 5;
        end
        RUN_WIDE: run_len = $urandom_range(65, 90);
        default: run_len = $urandom_range(1, 8);
      endcase
      base = {$urandom, $urandom};
      for (int j = 0; j < pool_n; j++) begin
        pool_bool[j] = $urandom_range(0, 99) < bool_pct;
        if (run_kind == RUN_FILL) begin
          pool_key[j] = base + 64'(j);
        end else if ($urandom_range(0, 2) == 0) begin
          pool_key[j] = 64'($urandom_range(0, 1));
        end else begin
          pool_key[j] = {$urandom, $urandom};
        end
      end
      for (int k = 0; k < run_len; k++) begin
        if (run_kind == RUN_NOISE) begin
          count_value(1'($urandom_range(0, 1)), {$urandom, $urandom},
                      1'($urandom_range(0, 1)));
        end else if (run_kind == RUN_WIDE) begin
          count_value(k == 0, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
        end else begin
          pick = $urandom_range(0, pool_n - 1);
          count_value(k == 0 || $urandom_range(0, 39) == 0, pool_key[pick], pool_bool[pick]);
        end
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[most_common_value_counter] OK");
    end else begin
      $display("[most_common_value_counter] ERROR");
    end
    $finish;
  end

endmodule

### files.f
sv/mcvc_pkg.sv
sv/mcvc_ram.sv
sv/mcvc_unit.sv
sv/most_common_value_counter.sv
dv/most_common_value_counter_checker.sv
dv/most_common_value_counter_tb.sv
